// ===== rtl/rfcac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfcac_pkg: shared types and constants for the frame CRC and address checker
// Holds field widths, the register count and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package rfcac_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned DevRegs   = 8;
  localparam int unsigned DevIdxW   = $clog2(DevRegs);
  localparam int unsigned ApbAddrW  = DevIdxW + 2;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned NumDeviceNumbersDefault = 8;

  localparam logic [WordW-1:0] CrcInit  = 16'hFFFF;
  localparam logic [ByteW-1:0] ByteMask = 8'hFF;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;

  // Position in frame, saturating at three
  typedef enum logic [1:0] {
    PosFirst  = 2'd0,
    PosSecond = 2'd1,
    PosThird  = 2'd2,
    PosBody   = 2'd3
  } pos_e;

  // Reflected CRC-16, polynomial 0x8408, one byte per call
  function automatic word_t crc_byte(input word_t crc, input byte_t b);
    byte_t d;
    d = (b ^ crc[7:0]) & ByteMask;
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rfcac_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfcac_byte_if: received byte channel
// Valid/ready channel carrying one frame byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface rfcac_byte_if;
  import rfcac_pkg::*;

  logic        valid;
  logic        ready;
  byte_t       rx_byte;
  logic        last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/rfcac_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfcac_result_if: frame check result channel
// Valid/ready channel carrying one check result per received frame.
// ----------------------------------------------------------------------------
interface rfcac_result_if;
  import rfcac_pkg::*;

  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic        address_match;
  word_t       frame_address;
  word_t       computed_crc;
  logic        too_short;

  modport source (output valid, output crc_ok, output address_match,
                  output frame_address, output computed_crc, output too_short,
                  input ready);
  modport sink   (input valid, input crc_ok, input address_match,
                  input frame_address, input computed_crc, input too_short,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/radio_frame_crc_address_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radio_frame_crc_address_checker: frame CRC-16 and device address check
// Bytes of a received frame enter on rx_i, one transaction per byte, with
// last_byte set on the final one. Bytes zero and one form a little-endian
// address; the reflected CRC-16 (0x8408, init 0xFFFF) covers all bytes but
// the trailing two, which carry the expected CRC low byte first.
// One transaction appears on res_o per frame, after its last byte only.
// Throughput is one byte per cycle: the byte sits in an input register, and
// one CRC byte update plus the address compares lead into the result
// register. res_o valid rises once a last byte has passed both registers.
// When res_o stalls, non-final bytes keep flowing; a final byte waits in the
// input register until the result register is free, and rx_i.ready drops
// only while that byte is held there.
// Device numbers are written over the APB port at byte address 4*i; only
// the first NumDeviceNumbers take part in the compare.
// Reset clears the frame state (CRC 0xFFFF, position zero), the device
// numbers and both valid flags.
// ----------------------------------------------------------------------------
module radio_frame_crc_address_checker #(
  parameter int unsigned NumDeviceNumbers = rfcac_pkg::NumDeviceNumbersDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  rfcac_byte_if.sink                          rx_i,
  rfcac_result_if.source                      res_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rfcac_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [rfcac_pkg::ApbDataW-1:0] pwdata,
  output logic      [rfcac_pkg::ApbDataW-1:0] prdata,
  output logic                                pready
);
  import rfcac_pkg::*;

  // Configuration registers
  word_t               dev_q [DevRegs];
  logic [DevIdxW-1:0]  reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DevRegs; i++) dev_q[i] <= '0;
    end else if (cfg_wr) begin
      for (int i = 0; i < DevRegs; i++) begin
        if (reg_idx == DevIdxW'(i)) dev_q[i] <= pwdata[WordW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < DevRegs; i++) begin
      if (reg_idx == DevIdxW'(i)) prdata = {{(ApbDataW-WordW){1'b0}}, dev_q[i]};
    end
  end

  // Input register
  logic  in_vld_q;
  byte_t in_byte_q;
  logic  in_last_q;
  logic  out_free;
  logic  proc_fire;

  assign out_free  = !res_o.valid || res_o.ready;
  assign proc_fire = in_vld_q && (!in_last_q || out_free);
  assign rx_i.ready = !in_vld_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
      in_last_q <= rx_i.last_byte;
    end
  end

  // Frame state
  word_t crc_q, crc_d;
  byte_t dly0_q, dly1_q;
  pos_e  pos_q, pos_d;
  word_t addr_q, addr_d;
  logic  short_frame;
  logic  match;
  word_t expected;

  always_comb begin
    crc_d = crc_q;
    if (pos_q == PosThird || pos_q == PosBody) crc_d = crc_byte(crc_q, dly1_q);

    case (pos_q)
      PosFirst:  addr_d = {8'h00, in_byte_q};
      PosSecond: addr_d = {in_byte_q, addr_q[ByteW-1:0]};
      default:   addr_d = addr_q;
    endcase

    case (pos_q)
      PosFirst:  pos_d = PosSecond;
      PosSecond: pos_d = PosThird;
      default:   pos_d = PosBody;
    endcase

    short_frame = (pos_q == PosFirst) || (pos_q == PosSecond);
    expected    = {in_byte_q, dly0_q};

    match = 1'b0;
    for (int i = 0; i < NumDeviceNumbers; i++) begin
      if (dev_q[i] == addr_d) match = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcInit;
      dly0_q <= '0;
      dly1_q <= '0;
      pos_q  <= PosFirst;
      addr_q <= '0;
    end else if (proc_fire) begin
      if (in_last_q) begin
        // End of frame: back to start-of-frame state
        crc_q  <= CrcInit;
        dly0_q <= '0;
        dly1_q <= '0;
        pos_q  <= PosFirst;
        addr_q <= '0;
      end else begin
        crc_q  <= crc_d;
        dly0_q <= in_byte_q;
        dly1_q <= dly0_q;
        pos_q  <= pos_d;
        addr_q <= addr_d;
      end
    end
  end

  // Result register
  logic res_load;
  assign res_load = proc_fire && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_o.valid <= 1'b0;
    end else if (res_load) begin
      res_o.valid <= 1'b1;
    end else if (res_o.ready) begin
      res_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_o.crc_ok        <= !short_frame && (crc_d == expected);
      res_o.address_match <= !short_frame && match;
      res_o.frame_address <= addr_d;
      res_o.computed_crc  <= short_frame ? CrcInit : crc_d;
      res_o.too_short     <= short_frame;
    end
  end

endmodule
`default_nettype wire
